// ===== hw/rtl/uar_pkg.sv =====
package uar_pkg;

	// Width of the converted value; input bits above it are ignored.
	localparam int VALUE_WIDTH = 32;
	localparam int IN_W = 32;
	localparam int CONV_W = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;

	// Digit counts per radix. Decimal uses floor(W * log10(2)) + 1.
	localparam int NHEX = (CONV_W + 3) / 4;
	localparam int NDEC = (CONV_W * 1233) / 4096 + 1;

	// Digit buffer of the emitter holds the longest left-aligned digit word.
	localparam int BUF_W = (4 * NDEC > 4 * NHEX) ? 4 * NDEC : 4 * NHEX;
	localparam int CNT_W = $clog2(CONV_W + 1);
	localparam int BIT_CNT_W = $clog2(CONV_W + 1);

	// Radix selector codes.
	localparam logic [1:0] KIND_BIN = 2'd0;
	localparam logic [1:0] KIND_DEC = 2'd1;
	localparam int KIND_HEX_BIT = 1;

	// ASCII codes.
	localparam logic [6:0] ASCII_ZERO = 7'd48;
	localparam logic [6:0] ASCII_NINE = 7'd57;
	localparam logic [6:0] ASCII_LOWER_A = 7'd97;
	localparam logic [6:0] ASCII_LOWER_F = 7'd102;
	localparam logic [3:0] DIGIT_TEN = 4'd10;

	// Load request from the top level into the emitter.
	typedef struct packed {
		logic             valid;
		logic [BUF_W-1:0] word;
		logic [CNT_W-1:0] ndig;
		logic             wide;
	} emit_load_t;

endpackage

// ===== hw/rtl/uar_dabble.sv =====
module uar_dabble (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [uar_pkg::CONV_W-1:0] value,
	output logic                      busy,
	output logic                      done,
	output logic [4*uar_pkg::NDEC-1:0] bcd
);
	import uar_pkg::*;

	logic [CONV_W-1:0]    sh_q;
	logic [4*NDEC-1:0]    bcd_q;
	logic [4*NDEC-1:0]    bcd_adj;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 done_q;

	// Add three to every BCD digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < NDEC; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Control: bit counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == BIT_CNT_W'(1));
			if (start) begin
				cnt_q <= BIT_CNT_W'(CONV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Datapath: shift one binary bit, most significant first, into the BCD word.
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			sh_q  <= sh_q << 1;
			bcd_q <= {bcd_adj[4*NDEC-2:0], sh_q[CONV_W-1]};
		end
	end

	assign busy = (cnt_q != '0) || done_q;
	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ===== hw/rtl/uar_emit.sv =====
module uar_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  uar_pkg::emit_load_t load,
	output logic                busy,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata, // [6:0] character, [7] zero fill
	output logic                m_tlast
);
	import uar_pkg::*;

	logic [BUF_W-1:0] word_q;
	logic [CNT_W-1:0] left_q;
	logic             wide_q;
	logic             seen_q;
	logic             valid_q;
	logic [6:0]       char_q;
	logic             last_q;

	logic [3:0]       digit;
	logic             show;
	logic             out_free;
	logic             step;
	logic [6:0]       ascii;

	// Pick the top digit and decide whether it is printed or skipped as a leading zero.
	always_comb begin
		if (wide_q) begin
			digit = word_q[BUF_W-1 -: 4];
		end else begin
			digit = {3'b000, word_q[BUF_W-1]};
		end
		show     = (left_q == CNT_W'(1)) || (digit != 4'd0) || seen_q;
		out_free = !valid_q || m_tready;
		step     = (left_q != '0) && (!show || out_free);
		if (digit < DIGIT_TEN) begin
			ascii = ASCII_ZERO + 7'(digit);
		end else begin
			ascii = ASCII_LOWER_A + 7'(digit - DIGIT_TEN);
		end
	end

	// Control: digit count, leading-zero flag and output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			seen_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load.valid) begin
				left_q <= load.ndig;
				seen_q <= 1'b0;
			end else if (step) begin
				left_q <= left_q - 1'b1;
				if (show) begin
					seen_q <= 1'b1;
				end
			end
			if (!load.valid && step && show) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Datapath: digit shift register and output register.
	always_ff @(posedge clk) begin
		if (load.valid) begin
			word_q <= load.word;
			wide_q <= load.wide;
		end else if (step) begin
			if (wide_q) begin
				word_q <= word_q << 4;
			end else begin
				word_q <= word_q << 1;
			end
			if (show) begin
				char_q <= ascii;
				last_q <= (left_q == CNT_W'(1));
			end
		end
	end

	assign busy     = (left_q != '0) || valid_q;
	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

endmodule

// ===== hw/rtl/unsigned_to_ascii_radix.sv =====
// Unsigned number to ASCII digit string converter.
// Slave channel: one beat per number. s_tdata carries the value, s_tuser the
// radix selector (0 binary, 1 decimal, 2 or 3 hexadecimal).
// Master channel: one beat per character, most significant digit first,
// leading zeros dropped; a zero value gives a single '0'. Hex digits above
// nine are lower-case. m_tlast marks the final character of each number.
// Binary and hex values go straight into the digit shift register; decimal
// values first pass a bit-serial double-dabble unit, one bit per cycle, that
// hands the BCD result over. The emitter then steps through every digit
// position, skipped leading zeros included: 32 positions for binary, 8 for
// hex, 10 for decimal.
// One number is converted at a time: s_tready is high only when the block
// holds no work and no pending output beat. A stalled receiver holds the
// current character in the output register and pauses the digit shift.
// Reset clears all control state; nothing is kept between numbers.
module unsigned_to_ascii_radix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [1:0]  s_tuser,  // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [6:0] character, [7] zero fill
	output logic        m_tlast
);
	import uar_pkg::*;

	logic               accept;
	logic [CONV_W-1:0]  v;
	logic               dab_start;
	logic               dab_busy;
	logic               dab_done;
	logic [4*NDEC-1:0]  dab_bcd;
	logic               emit_busy;
	emit_load_t         load;

	assign accept = s_tvalid && s_tready;
	assign v      = s_tdata[CONV_W-1:0];

	// Route the number: decimal through the BCD converter, others straight to the emitter.
	always_comb begin
		dab_start  = accept && (s_tuser == KIND_DEC);
		load.valid = 1'b0;
		load.word  = '0;
		load.ndig  = '0;
		load.wide  = 1'b0;
		if (dab_done) begin
			load.valid = 1'b1;
			load.word  = BUF_W'(dab_bcd) << (BUF_W - 4 * NDEC);
			load.ndig  = CNT_W'(NDEC);
			load.wide  = 1'b1;
		end else if (accept && s_tuser[KIND_HEX_BIT]) begin
			load.valid = 1'b1;
			load.word  = BUF_W'(v) << (BUF_W - 4 * NHEX);
			load.ndig  = CNT_W'(NHEX);
			load.wide  = 1'b1;
		end else if (accept && (s_tuser == KIND_BIN)) begin
			load.valid = 1'b1;
			load.word  = BUF_W'(v) << (BUF_W - CONV_W);
			load.ndig  = CNT_W'(CONV_W);
			load.wide  = 1'b0;
		end
	end

	assign s_tready = !dab_busy && !emit_busy;

	uar_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dab_start),
		.value  (v),
		.busy   (dab_busy),
		.done   (dab_done),
		.bcd    (dab_bcd)
	);

	uar_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.busy     (emit_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// No new number is taken while a character is still pending.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input accepted while output beat pending");

	// The BCD result only arrives when the emitter is free to take it.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		dab_done |-> !emit_busy)
		else $error("BCD result arrived while emitter busy");

	// Every output beat is a valid digit character.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[6:0] >= ASCII_ZERO) && (m_tdata[6:0] <= ASCII_NINE)) ||
		             ((m_tdata[6:0] >= ASCII_LOWER_A) && (m_tdata[6:0] <= ASCII_LOWER_F)))
		else $error("output character out of range");

	// An accepted number always starts work in one of the two units.
	a_accept_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (dab_busy || emit_busy))
		else $error("accepted number started no work");

endmodule
